// ----- src/tccw_pkg.sv -----
package tccw_pkg;

    // Field and register widths.
    localparam int ADDR_W     = 14;
    localparam int SIZE_W     = 15;
    localparam int END_W      = 16;
    localparam int DIST_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int STEP_W     = $clog2(ADDR_W);

    // Default geometry of the console.
    localparam int ROW_CELLS_DEF   = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int MARK_DEPTH_DEF  = 256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BACK    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // A tab is four spaces; popping a tab mark erases three more cells.
    localparam int TAB_SPACES = 4;
    localparam logic [DIST_W-1:0] TAB_EXTRA = 7'd3;

    // A backspace cascade stops after this many erased cells.
    localparam logic [COUNT_W-1:0] ERASE_LIMIT = 7'd127;

    // One entry of the line-break stack: position and the distance jumped.
    typedef struct packed {
        logic [ADDR_W-1:0] mark;
        logic [DIST_W-1:0] jump;
    } t_brk_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_step;
        logic nl_apply;
        logic nl_push;
        logic tab_step;
        logic tab_push;
        logic print_step;
        logic bs_step;
        logic scroll_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic bs_more;
        logic scroll_more;
    } t_dp_sts;

endpackage

// ----- src/tccw_ctrl.sv -----
module tccw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [tccw_pkg::CHAR_W-1:0] i_char_code,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output tccw_pkg::t_dp_cmd           o_cmd,
    input  tccw_pkg::t_dp_sts           i_sts
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_NL_DIV   = 11'b00000000010,
        S_NL_APPLY = 11'b00000000100,
        S_NL_PUSH  = 11'b00000001000,
        S_TAB      = 11'b00000010000,
        S_TAB_PUSH = 11'b00000100000,
        S_PRINT    = 11'b00001000000,
        S_BS_FETCH = 11'b00010000000,
        S_BS_STEP  = 11'b00100000000,
        S_SCROLL   = 11'b01000000000,
        S_OUT      = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    tccw_pkg::t_dp_cmd cmd;

    // Sequencing of one item through the datapath.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    if (i_char_code == tccw_pkg::CH_NEWLINE) begin
                        n_state = S_NL_DIV;
                    end else if (i_char_code == tccw_pkg::CH_TAB) begin
                        n_state = S_TAB;
                    end else if (i_char_code == tccw_pkg::CH_BACK) begin
                        n_state = S_BS_FETCH;
                    end else begin
                        n_state = S_PRINT;
                    end
                end
            end
            S_NL_DIV: begin
                cmd.div_step = 1'b1;
                n_state      = S_NL_APPLY;
            end
            S_NL_APPLY: begin
                cmd.nl_apply = 1'b1;
                n_state      = S_NL_PUSH;
            end
            S_NL_PUSH: begin
                cmd.nl_push = 1'b1;
                n_state     = S_SCROLL;
            end
            S_TAB: begin
                cmd.tab_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_TAB_PUSH;
                end
            end
            S_TAB_PUSH: begin
                cmd.tab_push = 1'b1;
                n_state      = S_SCROLL;
            end
            S_PRINT: begin
                cmd.print_step = 1'b1;
                n_state        = S_SCROLL;
            end
            S_BS_FETCH: begin
                n_state = S_BS_STEP;
            end
            S_BS_STEP: begin
                cmd.bs_step = 1'b1;
                n_state     = i_sts.bs_more ? S_BS_FETCH : S_SCROLL;
            end
            S_SCROLL: begin
                if (i_sts.scroll_more) begin
                    cmd.scroll_step = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register holds a result until the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule

// ----- src/tccw_datapath.sv -----
module tccw_datapath #(
    parameter int ROW_CELLS   = tccw_pkg::ROW_CELLS_DEF,
    parameter int SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int MARK_DEPTH  = tccw_pkg::MARK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                            i_highlight,
    input  tccw_pkg::t_dp_cmd               i_cmd,
    output tccw_pkg::t_dp_sts               o_sts,
    output logic [tccw_pkg::ADDR_W-1:0]     o_fill_start,
    output logic [tccw_pkg::COUNT_W-1:0]    o_fill_count,
    output logic [tccw_pkg::CHAR_W-1:0]     o_fill_char,
    output logic                            o_fill_highlight,
    output logic [tccw_pkg::ADDR_W-1:0]     o_cursor_pos,
    output logic [tccw_pkg::ADDR_W-1:0]     o_view_start
);

    localparam int AW      = tccw_pkg::ADDR_W;
    localparam int EW      = tccw_pkg::END_W;
    localparam int VW      = tccw_pkg::ADDR_W + 3;
    localparam int ROW_LOG = $clog2(ROW_CELLS);
    localparam int ROW_SH  = AW + ROW_LOG;
    localparam int RECIP   = ((1 << ROW_SH) + ROW_CELLS - 1) / ROW_CELLS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = AW + RECIP_W;
    localparam int ROW_W   = AW - ROW_LOG + 1;
    localparam int IDX_W   = $clog2(MARK_DEPTH);
    localparam int CNT_W   = $clog2(MARK_DEPTH + 1);
    localparam int PEND_W  = $clog2(2 * MARK_DEPTH * (1 << tccw_pkg::DIST_W) + 2);
    localparam int SCREEN_CELLS = ROW_CELLS * SCREEN_ROWS;

    // Region configuration and its precomputed end.
    logic [AW-1:0]                  r_base, n_base;
    logic [tccw_pkg::SIZE_W-1:0]    r_size, n_size;
    logic [EW-1:0]                  r_end, n_end;

    // Console state.
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [AW-1:0]    r_view, n_view;
    logic [CNT_W-1:0] r_tab_count, n_tab_count;
    logic [CNT_W-1:0] r_brk_count, n_brk_count;

    // Per-item working registers.
    logic [tccw_pkg::CHAR_W-1:0]  r_char, n_char;
    logic                         r_hl, n_hl;
    logic [AW-1:0]                r_before, n_before;
    logic [AW-1:0]                r_off, n_off;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [tccw_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic [PEND_W-1:0]            r_pending, n_pending;
    logic [tccw_pkg::COUNT_W-1:0] r_erased, n_erased;
    logic [VW-1:0]                r_v, n_v;

    // Result registers.
    logic [AW-1:0]                r_o_start, r_o_cursor, r_o_view;
    logic [tccw_pkg::COUNT_W-1:0] r_o_count;
    logic [tccw_pkg::CHAR_W-1:0]  r_o_char;
    logic                         r_o_hl;

    // Mark stacks with registered top reads.
    logic [AW-1:0]         tab_mem [MARK_DEPTH];
    tccw_pkg::t_brk_entry  brk_mem [MARK_DEPTH];
    logic [AW-1:0]         r_tab_top;
    tccw_pkg::t_brk_entry  r_brk_top;

    logic [CNT_W-1:0] tab_dec, brk_dec;
    logic             tab_room, brk_room;
    logic [EW-1:0]    cur_inc;
    logic             room_one, nl_room;
    logic [PROD_W-1:0] row_prod;
    logic [AW-1:0]    row_next;
    logic             tab_hit, brk_hit, can_back;
    logic [tccw_pkg::DIST_W-1:0]  extra;
    logic [PEND_W-1:0]            pend_nx;
    logic [tccw_pkg::COUNT_W-1:0] erased_nx;
    logic [VW-1:0]    scr_end;
    logic             is_nl, is_tab, is_bs, nothing;

    assign tab_dec  = r_tab_count - CNT_W'(1);
    assign brk_dec  = r_brk_count - CNT_W'(1);
    assign tab_room = (r_tab_count < CNT_W'(MARK_DEPTH));
    assign brk_room = (r_brk_count < CNT_W'(MARK_DEPTH));

    // Room checks against the region end.
    assign cur_inc  = {{(EW-AW){1'b0}}, r_cursor} + EW'(1);
    assign room_one = (cur_inc < r_end);
    assign nl_room  = (({{(EW-AW){1'b0}}, r_cursor} + EW'(ROW_CELLS)) < r_end);

    // Row of the cursor: the row offset times a fixed reciprocal of the row length.
    assign row_prod = PROD_W'(r_off) * PROD_W'(RECIP);
    assign row_next = AW'(r_row) + AW'(1);

    // Backspace step: test the stack tops against the cursor.
    assign tab_hit  = (r_tab_count != '0) && (r_tab_top == r_cursor);
    assign brk_hit  = !tab_hit && (r_brk_count != '0) && (r_brk_top.mark == r_cursor);
    assign can_back = (r_cursor > r_base);
    always_comb begin
        extra = '0;
        if (tab_hit) begin
            extra = tccw_pkg::TAB_EXTRA;
        end else if (brk_hit && (r_brk_top.jump != '0)) begin
            extra = r_brk_top.jump - tccw_pkg::DIST_W'(1);
        end
    end
    assign pend_nx   = r_pending - PEND_W'(1) + PEND_W'(extra);
    assign erased_nx = r_erased + tccw_pkg::COUNT_W'(can_back);

    // Scroll test on the candidate view.
    assign scr_end = r_v + VW'(SCREEN_CELLS);

    assign o_sts.cnt_zero    = (r_cnt == '0);
    assign o_sts.bs_more     = (pend_nx != '0) && (erased_nx < tccw_pkg::ERASE_LIMIT);
    assign o_sts.scroll_more = ({{(VW-AW){1'b0}}, r_cursor} >= scr_end) &&
                               (scr_end < {{(VW-EW){1'b0}}, r_end});

    assign is_nl   = (r_char == tccw_pkg::CH_NEWLINE);
    assign is_tab  = (r_char == tccw_pkg::CH_TAB);
    assign is_bs   = (r_char == tccw_pkg::CH_BACK);
    assign nothing = is_nl || (r_erased == '0);

    // Configuration writes.
    always_comb begin
        n_base = r_base;
        n_size = r_size;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tccw_pkg::CFG_REGION_BASE: n_base = i_cfg_data[AW-1:0];
                tccw_pkg::CFG_REGION_SIZE: n_size = i_cfg_data;
                default: begin
                    n_base = r_base;
                    n_size = r_size;
                end
            endcase
        end
        n_end = {{(EW-AW){1'b0}}, n_base} + {{(EW-tccw_pkg::SIZE_W){1'b0}}, n_size};
    end

    // Item processing.
    always_comb begin
        n_cursor    = r_cursor;
        n_view      = r_view;
        n_tab_count = r_tab_count;
        n_brk_count = r_brk_count;
        n_char      = r_char;
        n_hl        = r_hl;
        n_before    = r_before;
        n_off       = r_off;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_pending   = r_pending;
        n_erased    = r_erased;
        n_v         = r_v;

        if (i_cmd.accept) begin
            n_char    = i_char_code;
            n_hl      = i_highlight;
            n_before  = r_cursor;
            n_off     = r_cursor - r_base;
            n_cnt     = tccw_pkg::STEP_W'(tccw_pkg::TAB_SPACES - 1);
            n_pending = PEND_W'(1);
            n_erased  = '0;
            n_v       = {{(VW-AW){1'b0}}, r_view};
        end

        if (i_cmd.div_step) begin
            n_row = row_prod[ROW_SH +: ROW_W];
        end

        // Next row start is the region base plus one row past the cursor's row.
        if (i_cmd.nl_apply && nl_room) begin
            n_cursor = r_base + row_next * AW'(ROW_CELLS);
        end

        if (i_cmd.nl_push && brk_room) begin
            n_brk_count = r_brk_count + CNT_W'(1);
        end

        if (i_cmd.tab_step || i_cmd.print_step) begin
            if (room_one) begin
                n_cursor = cur_inc[AW-1:0];
                n_erased = r_erased + tccw_pkg::COUNT_W'(1);
            end
        end
        if (i_cmd.tab_step) begin
            n_cnt = r_cnt - tccw_pkg::STEP_W'(1);
        end

        if (i_cmd.tab_push && tab_room) begin
            n_tab_count = r_tab_count + CNT_W'(1);
        end

        if (i_cmd.bs_step) begin
            if (tab_hit) begin
                n_tab_count = tab_dec;
            end else if (brk_hit) begin
                n_brk_count = brk_dec;
            end
            if (can_back) begin
                n_cursor = r_cursor - AW'(1);
            end
            n_erased  = erased_nx;
            n_pending = pend_nx;
        end

        if (i_cmd.scroll_step) begin
            n_v = r_v + VW'(ROW_CELLS);
        end

        if (i_cmd.out_load) begin
            n_view = r_v[AW-1:0];
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= tccw_pkg::SIZE_W'(1 << AW);
            r_end       <= EW'(1 << AW);
            r_cursor    <= '0;
            r_view      <= '0;
            r_tab_count <= '0;
            r_brk_count <= '0;
        end else begin
            r_base      <= n_base;
            r_size      <= n_size;
            r_end       <= n_end;
            r_cursor    <= n_cursor;
            r_view      <= n_view;
            r_tab_count <= n_tab_count;
            r_brk_count <= n_brk_count;
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_hl      <= n_hl;
        r_before  <= n_before;
        r_off     <= n_off;
        r_row     <= n_row;
        r_cnt     <= n_cnt;
        r_pending <= n_pending;
        r_erased  <= n_erased;
        r_v       <= n_v;
    end

    // Tab mark stack.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_push && tab_room) begin
            tab_mem[r_tab_count[IDX_W-1:0]] <= r_cursor;
        end
        r_tab_top <= tab_mem[tab_dec[IDX_W-1:0]];
    end

    // Line-break stack: position and the distance jumped.
    always_ff @(posedge i_clk) begin
        if (i_cmd.nl_push && brk_room) begin
            brk_mem[r_brk_count[IDX_W-1:0]] <= '{mark: r_cursor,
                                                 jump: tccw_pkg::DIST_W'(r_cursor - r_before)};
        end
        r_brk_top <= brk_mem[brk_dec[IDX_W-1:0]];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_start  <= (nothing || is_bs) ? r_cursor : r_before;
            r_o_count  <= nothing ? '0 : r_erased;
            r_o_char   <= nothing ? '0 : ((is_bs || is_tab) ? tccw_pkg::CH_SPACE : r_char);
            r_o_hl     <= (nothing || is_bs) ? 1'b0 : r_hl;
            r_o_cursor <= r_cursor;
            r_o_view   <= r_v[AW-1:0];
        end
    end

    assign o_fill_start     = r_o_start;
    assign o_fill_count     = r_o_count;
    assign o_fill_char      = r_o_char;
    assign o_fill_highlight = r_o_hl;
    assign o_cursor_pos     = r_o_cursor;
    assign o_view_start     = r_o_view;

endmodule

// ----- src/text_console_char_writer.sv -----
// Text console character writer. Each item is one character code with a highlight bit;
// it yields exactly one result describing the run of cells written (start, count,
// character, colour) together with the cursor and first displayed cell afterwards. The
// work for an item varies with its code and is set by a sequencer that walks a shared
// datapath: a printable code takes a print step, a tab one step per space, a newline a
// division, an apply and a push step (the cursor's row is found by multiplying its row
// offset with a fixed reciprocal of the row length), a backspace a fetch and an erase
// step per cascade step (each fetch reads the stack tops from the mark memories), and
// each row scrolled adds a scroll step. The next item is taken as soon as the result sits
// in the output register, even while the sink stalls it. The mark stacks need no clearing
// after reset. Configuration writes must be made only between items; the block does not enforce it.
module text_console_char_writer #(
    parameter int ROW_CELLS   = tccw_pkg::ROW_CELLS_DEF,
    parameter int SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int MARK_DEPTH  = tccw_pkg::MARK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                            i_highlight,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tccw_pkg::ADDR_W-1:0]     o_fill_start,
    output logic [tccw_pkg::COUNT_W-1:0]    o_fill_count,
    output logic [tccw_pkg::CHAR_W-1:0]     o_fill_char,
    output logic                            o_fill_highlight,
    output logic [tccw_pkg::ADDR_W-1:0]     o_cursor_pos,
    output logic [tccw_pkg::ADDR_W-1:0]     o_view_start
);

    tccw_pkg::t_dp_cmd cmd;
    tccw_pkg::t_dp_sts sts;

    // Sequencer.
    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Cursor, view, mark stacks and result register.
    tccw_datapath #(
        .ROW_CELLS   (ROW_CELLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .MARK_DEPTH  (MARK_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_char_code      (i_char_code),
        .i_highlight      (i_highlight),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_fill_start     (o_fill_start),
        .o_fill_count     (o_fill_count),
        .o_fill_char      (o_fill_char),
        .o_fill_highlight (o_fill_highlight),
        .o_cursor_pos     (o_cursor_pos),
        .o_view_start     (o_view_start)
    );

endmodule
